// ===== src/tcp_flow_tracker_macros.svh =====
// assertion macros for the tcp flow tracker
// no dependencies; included by the top level before its module body
`ifndef TCP_FLOW_TRACKER_MACROS_SVH
`define TCP_FLOW_TRACKER_MACROS_SVH

// clocked check, disabled while reset is asserted (active low)
`define TFT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// next-cycle implication check, disabled while reset is asserted
`define TFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tft_pkg.sv =====
// shared types and constants for the tcp flow tracker
// no dependencies; imported by tcp_flow_tracker and its testbench
package tft_pkg;

    // field widths
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned USEC_W  = 20;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned FLAGS_W = 8;
    localparam int unsigned THR_W   = 8;

    // stream packing
    localparam int unsigned S_TDATA_W = 120;
    localparam int unsigned S_TUSER_W = 10;
    localparam int unsigned M_TDATA_W = 216;
    localparam int unsigned M_TUSER_W = 2;

    // tcp flag bit positions and the pure syn code
    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_RST_BIT = 2;
    localparam int unsigned FLAG_ACK_BIT = 4;
    localparam logic [FLAGS_W-1:0] FLAGS_PURE_SYN = 8'h02;

    localparam int unsigned USEC_PER_SEC = 1000000;
    localparam logic [THR_W-1:0] RST_MIN_CLIENT_RESET = 8'd4;

    typedef enum logic [1:0] {
        VERDICT_COUNTED = 2'd0,
        VERDICT_STORE   = 2'd1,
        VERDICT_DROPPED = 2'd2,
        VERDICT_CLOSED  = 2'd3
    } verdict_t;

    // per-flow record
    typedef struct packed {
        logic [SEC_W-1:0]  syn_sec;
        logic [USEC_W-1:0] syn_us;
        logic [CNT_W-1:0]  rtt;
        logic [CNT_W-1:0]  cli_pkts;
        logic [CNT_W-1:0]  srv_pkts;
        logic [CNT_W-1:0]  cli_bytes;
        logic [CNT_W-1:0]  srv_bytes;
        logic [SEC_W-1:0]  last_sec;
        logic [USEC_W-1:0] last_usec;
    } flow_rec_t;

endpackage

// ===== src/tcp_flow_tracker.sv =====
// tcp_flow_tracker: single tcp flow tracker, depends on tft_pkg and the macros header
// pipeline: input register, then result register; throughput: one packet per cycle
//   while m_tready does not stall the result register; the flow record updates in a
//   single pass of compare and add logic plus one 32x20 constant multiply for rtt
// reset: aresetn synchronous active low; clears the flow record, both valid flags,
//   and sets rst_min_client_packets to 4
`include "tcp_flow_tracker_macros.svh"

module tcp_flow_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: rst_min_client_packets
    input  logic                            cfg_we,
    input  logic [tft_pkg::THR_W-1:0]       cfg_wdata,
    // input packets
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // capture_sec, capture_usec, payload_len, now_sec, now_usec
    input  logic [tft_pkg::S_TDATA_W-1:0]   s_tdata,
    // from_client, pkt_flags, has_payload
    input  logic [tft_pkg::S_TUSER_W-1:0]   s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rtt_us, client_packets, server_packets, client_bytes, server_bytes,
    // last_active_sec, last_active_usec, zero pad
    output logic [tft_pkg::M_TDATA_W-1:0]   m_tdata,
    // verdict
    output logic [tft_pkg::M_TUSER_W-1:0]   m_tuser
);
    import tft_pkg::*;

    // configuration register
    logic [THR_W-1:0] thr_reg;

    // input stage
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_client_reg;
    logic [FLAGS_W-1:0] in_flags_reg;
    logic [SEC_W-1:0]   in_csec_reg;
    logic [USEC_W-1:0]  in_cusec_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic               in_payload_reg;
    logic [SEC_W-1:0]   in_nsec_reg;
    logic [USEC_W-1:0]  in_nusec_reg;

    // flow record and result stage
    flow_rec_t rec_reg;
    flow_rec_t rec_next;
    flow_rec_t rec_out;
    flow_rec_t out_rec_reg;
    verdict_t  verdict;
    verdict_t  out_verdict_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic s_accept;
    logic advance;
    logic fire;
    logic clear_flow;

    logic is_rst;
    logic is_fin;
    logic hs_ack;
    logic client_syn;
    logic below_thr;
    logic [CNT_W-1:0] diff_sec;
    logic [CNT_W-1:0] diff_usec;
    logic [CNT_W-1:0] rtt_calc;

    // count one packet into a record
    function automatic flow_rec_t count_pkt(
        input flow_rec_t         r,
        input logic              cli,
        input logic [LEN_W-1:0]  len,
        input logic [SEC_W-1:0]  ns,
        input logic [USEC_W-1:0] nus
    );
        flow_rec_t c;
        c = r;
        if (cli) begin
            c.cli_pkts  = r.cli_pkts + CNT_W'(1);
            c.cli_bytes = r.cli_bytes + CNT_W'(len);
        end else begin
            c.srv_pkts  = r.srv_pkts + CNT_W'(1);
            c.srv_bytes = r.srv_bytes + CNT_W'(len);
        end
        c.last_sec  = ns;
        c.last_usec = nus;
        return c;
    endfunction

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // packet classification; the update below takes reset, then handshake ack, fin, client syn
    assign is_rst     = in_flags_reg[FLAG_RST_BIT];
    assign is_fin     = in_flags_reg[FLAG_FIN_BIT];
    assign hs_ack     = in_client_reg && (rec_reg.cli_pkts == CNT_W'(1))
                        && in_flags_reg[FLAG_ACK_BIT];
    assign client_syn = in_client_reg && (in_flags_reg == FLAGS_PURE_SYN);
    assign below_thr  = rec_reg.cli_pkts < CNT_W'(thr_reg);

    // handshake round trip, modulo 2^32
    assign diff_sec  = in_csec_reg - rec_reg.syn_sec;
    assign diff_usec = CNT_W'(in_cusec_reg) - CNT_W'(rec_reg.syn_us);
    assign rtt_calc  = CNT_W'(diff_sec * CNT_W'(USEC_PER_SEC)) + diff_usec;

    // record update and verdict
    always_comb begin
        flow_rec_t base;
        base       = rec_reg;
        rec_out    = rec_reg;
        verdict    = VERDICT_COUNTED;
        clear_flow = 1'b0;
        if (is_rst) begin
            clear_flow = 1'b1;
            if (below_thr) begin
                verdict = VERDICT_DROPPED;
            end else begin
                rec_out = count_pkt(rec_reg, in_client_reg, in_len_reg,
                                    in_nsec_reg, in_nusec_reg);
                verdict = VERDICT_CLOSED;
            end
        end else if (hs_ack) begin
            rec_out     = count_pkt(rec_reg, in_client_reg, in_len_reg,
                                    in_nsec_reg, in_nusec_reg);
            rec_out.rtt = rtt_calc;
        end else if (is_fin) begin
            clear_flow = 1'b1;
            rec_out    = count_pkt(rec_reg, in_client_reg, in_len_reg,
                                   in_nsec_reg, in_nusec_reg);
            verdict    = VERDICT_CLOSED;
        end else if (client_syn) begin
            // repeated syn restarts the flow
            if (rec_reg.cli_pkts != '0) begin
                base = '0;
            end
            rec_out = count_pkt(base, in_client_reg, in_len_reg,
                                in_nsec_reg, in_nusec_reg);
            rec_out.syn_sec = in_csec_reg;
            rec_out.syn_us  = in_cusec_reg;
        end else begin
            rec_out = count_pkt(rec_reg, in_client_reg, in_len_reg,
                                in_nsec_reg, in_nusec_reg);
            verdict = in_payload_reg ? VERDICT_STORE : VERDICT_COUNTED;
        end
        if (fire) begin
            rec_next = clear_flow ? '0 : rec_out;
        end else begin
            rec_next = rec_reg;
        end
    end

    // control and flow state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= RST_MIN_CLIENT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rec_reg       <= '0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            rec_reg       <= rec_next;
        end
    end

    // input payload capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_client_reg  <= s_tuser[0];
            in_flags_reg   <= s_tuser[8:1];
            in_payload_reg <= s_tuser[9];
            in_csec_reg    <= s_tdata[31:0];
            in_cusec_reg   <= s_tdata[51:32];
            in_len_reg     <= s_tdata[67:52];
            in_nsec_reg    <= s_tdata[99:68];
            in_nusec_reg   <= s_tdata[119:100];
        end
    end

    // result payload capture
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_rec_reg     <= rec_out;
            out_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_verdict_reg;
    assign m_tdata  = {4'b0000,
                       out_rec_reg.last_usec,
                       out_rec_reg.last_sec,
                       out_rec_reg.srv_bytes,
                       out_rec_reg.cli_bytes,
                       out_rec_reg.srv_pkts,
                       out_rec_reg.cli_pkts,
                       out_rec_reg.rtt};

    // checks
    `TFT_ASSERT_NEXT(a_close_clears, aclk, aresetn, fire && clear_flow, (rec_reg.cli_pkts == '0) && (rec_reg.srv_pkts == '0) && (rec_reg.last_sec == '0), "flow not cleared after drop or close")
    `TFT_ASSERT_NEXT(a_idle_holds_state, aclk, aresetn, !fire, $stable(rec_reg), "flow record changed without a packet")
    `TFT_ASSERT_NEXT(a_stage_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_flags_reg) && $stable(in_nsec_reg), "stalled input stage lost its packet")
    `TFT_ASSERT(a_ready_when_free, aclk, aresetn, !in_valid_reg |-> s_tready, "input not ready with empty stage")

endmodule

// ===== sim/tcp_flow_tracker_test.sv =====
// self-checking testbench for tcp_flow_tracker: directed flows, threshold sweeps,
// random traffic under idle and stall patterns, and a long full-size payload run
// depends on tft_pkg and the tcp_flow_tracker rtl
module tcp_flow_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tft_pkg::*;

    // flag bytes used by the traffic generators
    localparam logic [FLAGS_W-1:0] FL_NONE     = 8'h00;
    localparam logic [FLAGS_W-1:0] FL_FIN      = 8'h01;
    localparam logic [FLAGS_W-1:0] FL_SYN_FIN  = 8'h03;
    localparam logic [FLAGS_W-1:0] FL_RST      = 8'h04;
    localparam logic [FLAGS_W-1:0] FL_ACK      = 8'h10;
    localparam logic [FLAGS_W-1:0] FL_FIN_ACK  = 8'h11;
    localparam logic [FLAGS_W-1:0] FL_SYN_ACK  = 8'h12;
    localparam logic [FLAGS_W-1:0] FL_RST_ACK  = 8'h14;
    localparam logic [FLAGS_W-1:0] FL_PSH_ACK  = 8'h18;
    localparam logic [FLAGS_W-1:0] FL_ALL      = 8'hFF;

    localparam logic [USEC_W-1:0] USEC_MAX  = 20'd999999;
    localparam logic [USEC_W-1:0] USEC_OVER = 20'hFFFFF;
    localparam logic [SEC_W-1:0]  SEC_MAX   = 32'hFFFFFFFF;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 16'hFFFF;

    typedef struct packed {
        logic               from_client;
        logic [FLAGS_W-1:0] flags;
        logic [SEC_W-1:0]   cap_sec;
        logic [USEC_W-1:0]  cap_us;
        logic [LEN_W-1:0]   len;
        logic               has_payload;
        logic [SEC_W-1:0]   now_sec;
        logic [USEC_W-1:0]  now_usec;
    } tcp_pkt_t;

    // verdict plus flow record snapshot, as one result carries it
    typedef struct packed {
        logic [1:0]        verdict;
        logic [CNT_W-1:0]  rtt;
        logic [CNT_W-1:0]  cli_pkts;
        logic [CNT_W-1:0]  srv_pkts;
        logic [CNT_W-1:0]  cli_bytes;
        logic [CNT_W-1:0]  srv_bytes;
        logic [SEC_W-1:0]  last_sec;
        logic [USEC_W-1:0] last_usec;
    } flow_snap_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [THR_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // capture_sec, capture_usec, payload_len, now_sec, now_usec
    logic [S_TUSER_W-1:0]  s_tuser;   // from_client, pkt_flags, has_payload
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // rtt_us, client/server packets, client/server bytes,
                                      // last_active_sec, last_active_usec, zero pad
    logic [M_TUSER_W-1:0]  m_tuser;   // verdict

    // shadow flow record and threshold
    flow_rec_t        trk;
    logic [THR_W-1:0] trk_rst_min;
    flow_snap_t       pending_snaps[$];

    int unsigned pkts_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    tcp_flow_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #100000;
        $display("FAIL");
        $finish;
    end

    // ---------------- flow record predictor ----------------

    function automatic flow_snap_t take_snap(input verdict_t v);
        flow_snap_t s;
        s.verdict   = v;
        s.rtt       = trk.rtt;
        s.cli_pkts  = trk.cli_pkts;
        s.srv_pkts  = trk.srv_pkts;
        s.cli_bytes = trk.cli_bytes;
        s.srv_bytes = trk.srv_bytes;
        s.last_sec  = trk.last_sec;
        s.last_usec = trk.last_usec;
        return s;
    endfunction

    function automatic void count_pkt(input tcp_pkt_t p);
        if (p.from_client) begin
            trk.cli_pkts  = trk.cli_pkts + 32'd1;
            trk.cli_bytes = trk.cli_bytes + 32'(p.len);
        end else begin
            trk.srv_pkts  = trk.srv_pkts + 32'd1;
            trk.srv_bytes = trk.srv_bytes + 32'(p.len);
        end
        trk.last_sec  = p.now_sec;
        trk.last_usec = p.now_usec;
    endfunction

    function automatic flow_snap_t update_flow(input tcp_pkt_t p);
        flow_snap_t s;
        logic [31:0] dsec;
        logic [31:0] dusec;
        if (p.flags[FLAG_RST_BIT]) begin
            // reset: drop young flows uncounted, else count and close
            if (trk.cli_pkts < 32'(trk_rst_min)) begin
                s = take_snap(VERDICT_DROPPED);
            end else begin
                count_pkt(p);
                s = take_snap(VERDICT_CLOSED);
            end
            trk = '0;
        end else if (p.from_client && trk.cli_pkts == 32'd1 && p.flags[FLAG_ACK_BIT]) begin
            // third handshake packet: round trip from the syn capture time
            dsec  = p.cap_sec - trk.syn_sec;
            dusec = 32'(p.cap_us) - 32'(trk.syn_us);
            trk.rtt = dsec * 32'(USEC_PER_SEC) + dusec;
            count_pkt(p);
            s = take_snap(VERDICT_COUNTED);
        end else if (p.flags[FLAG_FIN_BIT]) begin
            count_pkt(p);
            s = take_snap(VERDICT_CLOSED);
            trk = '0;
        end else if (p.from_client && p.flags == FLAGS_PURE_SYN) begin
            // a repeated syn starts the flow over
            if (trk.cli_pkts != 32'd0)
                trk = '0;
            trk.syn_sec = p.cap_sec;
            trk.syn_us  = p.cap_us;
            count_pkt(p);
            s = take_snap(VERDICT_COUNTED);
        end else begin
            count_pkt(p);
            s = take_snap(p.has_payload ? VERDICT_STORE : VERDICT_COUNTED);
        end
        return s;
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge aclk) begin : flow_monitor
        tcp_pkt_t   p;
        flow_snap_t got;
        flow_snap_t exp_snap;
        if (!aresetn) begin
            trk         = '0;
            trk_rst_min = RST_MIN_CLIENT_RESET;
            pending_snaps.delete();
        end else begin
            // result transaction
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.verdict   = m_tuser;
                got.rtt       = m_tdata[31:0];
                got.cli_pkts  = m_tdata[63:32];
                got.srv_pkts  = m_tdata[95:64];
                got.cli_bytes = m_tdata[127:96];
                got.srv_bytes = m_tdata[159:128];
                got.last_sec  = m_tdata[191:160];
                got.last_usec = m_tdata[211:192];
                if (pending_snaps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: verdict=%0d", $realtime,
                                 got.verdict);
                end else begin
                    exp_snap = pending_snaps.pop_front();
                    if (got !== exp_snap) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  exp v=%0d rtt=%h cp=%h sp=%h cb=%h sb=%h ls=%h lu=%h",
                                     exp_snap.verdict, exp_snap.rtt, exp_snap.cli_pkts,
                                     exp_snap.srv_pkts, exp_snap.cli_bytes,
                                     exp_snap.srv_bytes, exp_snap.last_sec,
                                     exp_snap.last_usec);
                            $display("  got v=%0d rtt=%h cp=%h sp=%h cb=%h sb=%h ls=%h lu=%h",
                                     got.verdict, got.rtt, got.cli_pkts, got.srv_pkts,
                                     got.cli_bytes, got.srv_bytes, got.last_sec,
                                     got.last_usec);
                        end
                    end
                end
            end
            // register write
            if (cfg_we)
                trk_rst_min = cfg_wdata;
            // input transaction
            if (s_tvalid && s_tready) begin
                p.cap_sec     = s_tdata[31:0];
                p.cap_us      = s_tdata[51:32];
                p.len         = s_tdata[67:52];
                p.now_sec     = s_tdata[99:68];
                p.now_usec    = s_tdata[119:100];
                p.from_client = s_tuser[0];
                p.flags       = s_tuser[8:1];
                p.has_payload = s_tuser[9];
                pending_snaps.push_back(update_flow(p));
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------- stimulus helpers ----------------

    function automatic tcp_pkt_t mk_pkt(input logic cl, input logic [FLAGS_W-1:0] fl,
                                        input logic [SEC_W-1:0] cs,
                                        input logic [USEC_W-1:0] cu,
                                        input logic [LEN_W-1:0] ln, input logic pl,
                                        input logic [SEC_W-1:0] ns,
                                        input logic [USEC_W-1:0] nu);
        tcp_pkt_t p;
        p.from_client = cl;
        p.flags       = fl;
        p.cap_sec     = cs;
        p.cap_us      = cu;
        p.len         = ln;
        p.has_payload = pl;
        p.now_sec     = ns;
        p.now_usec    = nu;
        return p;
    endfunction

    // mostly legal microseconds, sometimes any 20-bit value
    function automatic logic [USEC_W-1:0] rand_usec();
        if ($urandom_range(9) == 0)
            return 20'($urandom);
        return 20'($urandom_range(999999));
    endfunction

    function automatic tcp_pkt_t rand_pkt(input logic cl, input logic [FLAGS_W-1:0] fl);
        return mk_pkt(cl, fl, $urandom, rand_usec(), 16'($urandom), 1'($urandom),
                      $urandom, rand_usec());
    endfunction

    // one input transaction; valid stays high on return unless a gap follows
    task automatic send_pkt(input tcp_pkt_t p);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.now_usec, p.now_sec, p.len, p.cap_us, p.cap_sec};
        s_tuser  <= {p.has_payload, p.flags, p.from_client};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pkts_sent++;
    endtask

    // drop valid and wait until every result has come back
    task automatic wait_flow_idle();
        s_tvalid <= 1'b0;
        while (results_seen < pkts_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_rst_min(input logic [THR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // a full handshake, some data, then a random ending; or a burst of noise
    task automatic send_traffic(input int unsigned n_items);
        int unsigned target;
        tcp_pkt_t    syn_pkt;
        tcp_pkt_t    p;
        target = pkts_sent + n_items;
        while (pkts_sent < target) begin
            if ($urandom_range(99) < 75) begin
                syn_pkt = rand_pkt(1'b1, FLAGS_PURE_SYN);
                send_pkt(syn_pkt);
                if ($urandom_range(19) != 0)
                    send_pkt(rand_pkt(1'b0, FL_SYN_ACK));
                p = rand_pkt(1'b1, FL_ACK);
                p.cap_sec = syn_pkt.cap_sec + 32'($urandom_range(2));
                send_pkt(p);
                repeat ($urandom_range(12))
                    send_pkt(rand_pkt(1'($urandom), $urandom_range(1) ? FL_PSH_ACK : FL_ACK));
                case ($urandom_range(3))
                    0: send_pkt(rand_pkt(1'($urandom), FL_FIN_ACK));
                    1: send_pkt(rand_pkt(1'($urandom), FL_RST_ACK));
                    2: ;
                    default: send_pkt(rand_pkt(1'b1, FLAGS_PURE_SYN));
                endcase
            end else begin
                repeat ($urandom_range(1, 6))
                    send_pkt(rand_pkt(1'($urandom), 8'($urandom)));
            end
        end
        wait_flow_idle();
    endtask

    // ---------------- tests ----------------

    // handshake, data, close, drop, repeated syn and flag priorities
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_pkt(mk_pkt(1'b1, FLAGS_PURE_SYN, 32'd100, USEC_MAX, 16'd0, 1'b0,
                        32'd100, 20'd1));
        send_pkt(mk_pkt(1'b0, FL_SYN_ACK, 32'd100, 20'd3, 16'd0, 1'b0, 32'd100, 20'd2));
        send_pkt(mk_pkt(1'b1, FL_ACK, 32'd101, 20'd5, 16'd0, 1'b0, 32'd101, 20'd3));
        send_pkt(mk_pkt(1'b1, FL_PSH_ACK, 32'd102, 20'd0, LEN_MAX, 1'b1, 32'd102, 20'd4));
        send_pkt(mk_pkt(1'b0, FL_PSH_ACK, 32'd103, 20'd0, LEN_MAX, 1'b0, 32'd103, 20'd5));
        send_pkt(mk_pkt(1'b1, FL_FIN, 32'd104, 20'd0, 16'd1, 1'b1, 32'd104, USEC_MAX));
        // reset while the flow is young
        send_pkt(mk_pkt(1'b1, FL_RST, 32'd105, 20'd0, 16'd7, 1'b1, 32'd105, 20'd6));
        // pure syn from the server side is an ordinary packet
        send_pkt(mk_pkt(1'b0, FLAGS_PURE_SYN, 32'd106, 20'd0, 16'd9, 1'b1,
                        32'd106, 20'd7));
        // extreme capture time and out-of-range microseconds, then wrapping round trip
        send_pkt(mk_pkt(1'b1, FLAGS_PURE_SYN, SEC_MAX, USEC_OVER, 16'd0, 1'b0,
                        SEC_MAX, USEC_OVER));
        send_pkt(mk_pkt(1'b1, FL_FIN_ACK, 32'd0, 20'd0, 16'd2, 1'b0, 32'd0, 20'd0));
        // repeated syn restarts the record
        send_pkt(mk_pkt(1'b1, FLAGS_PURE_SYN, 32'd200, 20'd10, 16'd3, 1'b0,
                        32'd200, 20'd8));
        send_pkt(mk_pkt(1'b1, FL_SYN_FIN, 32'd201, 20'd11, 16'd4, 1'b1, 32'd201, 20'd9));
        // every flag set: reset has priority
        send_pkt(mk_pkt(1'b1, FLAGS_PURE_SYN, 32'd300, 20'd1, 16'd0, 1'b0,
                        32'd300, 20'd1));
        send_pkt(mk_pkt(1'b0, FL_ALL, 32'd300, 20'd2, LEN_MAX, 1'b1, 32'd300, 20'd2));
        // four client packets, then a reset that closes
        send_pkt(mk_pkt(1'b1, FLAGS_PURE_SYN, 32'd400, 20'd500, 16'd0, 1'b0,
                        32'd400, 20'd1));
        send_pkt(mk_pkt(1'b1, FL_ACK, 32'd400, 20'd100, 16'd0, 1'b0, 32'd400, 20'd2));
        send_pkt(mk_pkt(1'b1, FL_PSH_ACK, 32'd401, 20'd0, 16'd100, 1'b1, 32'd401, 20'd3));
        send_pkt(mk_pkt(1'b1, FL_PSH_ACK, 32'd402, 20'd0, 16'd200, 1'b1, 32'd402, 20'd4));
        send_pkt(mk_pkt(1'b1, FL_RST_ACK, 32'd403, 20'd0, 16'd5, 1'b0, 32'd403, 20'd5));
        // no flags, extreme processing time
        send_pkt(mk_pkt(1'b1, FL_NONE, 32'd0, 20'd0, 16'd10, 1'b1, SEC_MAX, USEC_MAX));
        // ack bit in a client syn-ack at count one takes the round trip
        send_pkt(mk_pkt(1'b1, FL_SYN_ACK, 32'd5, 20'd5, 16'd1, 1'b1, 32'd5, 20'd5));
        send_pkt(mk_pkt(1'b0, FL_FIN, 32'd6, 20'd0, 16'd1, 1'b0, 32'd6, 20'd6));
        wait_flow_idle();
    endtask

    // reset at client counts on both sides of several thresholds
    task automatic test_rst_threshold();
        logic [THR_W-1:0] thr_list[4];
        thr_list = '{8'd0, 8'd1, 8'd2, 8'd255};
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        foreach (thr_list[i]) begin
            write_rst_min(thr_list[i]);
            for (int n = 0; n < 4; n++) begin
                if (n > 0)
                    send_pkt(rand_pkt(1'b1, FLAGS_PURE_SYN));
                for (int k = 1; k < n; k++)
                    send_pkt(rand_pkt(1'b1, FL_PSH_ACK));
                send_pkt(rand_pkt(1'($urandom), FL_RST));
            end
            wait_flow_idle();
        end
    endtask

    // random traffic under each idle pattern and threshold setting
    task automatic test_random_traffic();
        int unsigned      idle_list[4];
        int unsigned      stall_list[4];
        logic [THR_W-1:0] thr_list[4];
        idle_list  = '{0, 72, 0, 36};
        stall_list = '{0, 0, 72, 36};
        thr_list   = '{RST_MIN_CLIENT_RESET, 8'd0, 8'd255, 8'($urandom_range(1, 9))};
        foreach (idle_list[i]) begin
            write_rst_min(thr_list[i]);
            src_idle_pct   = idle_list[i];
            sink_stall_pct = stall_list[i];
            send_traffic(400);
        end
    endtask

    // long client flow of full-size payloads
    task automatic test_long_flow();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_pkt(rand_pkt(1'b1, FLAGS_PURE_SYN));
        send_pkt(rand_pkt(1'b0, FL_SYN_ACK));
        send_pkt(rand_pkt(1'b1, FL_ACK));
        repeat (200)
            send_pkt(mk_pkt(1'b1, FL_PSH_ACK, $urandom, 20'd0, LEN_MAX, 1'b1,
                            $urandom, 20'd0));
        send_pkt(rand_pkt(1'b0, FL_FIN_ACK));
        wait_flow_idle();
    endtask

    // ---------------- main sequence ----------------

    initial begin
        pkts_sent      = 0;
        results_seen   = 0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_rst_threshold();
        test_random_traffic();
        test_long_flow();

        if (mismatches == 0 && pending_snaps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
